// ----- hdl/dep_pkg.sv -----
// shared types, constants and codes for the double-ended priority queue
`default_nettype none

package dep_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // command codes
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_POP_MAX = 2'd1;
    localparam logic [1:0] CMD_POP_MIN = 2'd2;

    // result status codes
    localparam logic [2:0] ST_POPPED   = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // memory read address select
    localparam logic [1:0] RD_MID   = 2'd0;
    localparam logic [1:0] RD_LAST  = 2'd1;
    localparam logic [1:0] RD_FIRST = 2'd2;
    localparam logic [1:0] RD_BELOW = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [31:0]  key;
        logic signed [31:0]  payload;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0]  result_value;
        logic [2:0]          status;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0]  key;
        logic signed [31:0]  payload;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic        in_load;
        logic        srch_init;
        logic        cmp_upd;
        logic        rd_en;
        logic [1:0]  rd_sel;
        logic        idx_init;
        logic        idx_dec;
        logic        wr_shift;
        logic        wr_new;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        head_inc;
        logic        res_set;
        logic        res_from_mem;
        logic [2:0]  res_status;
        logic        out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0]  op;
        logic        cnt_zero;
        logic        cnt_full;
        logic        lo_eq_hi;
        logic        idx_eq_lo;
        logic        found;
        logic        out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/dep_ctrl.sv -----
// sequencing state machine for the double-ended priority queue
`default_nettype none

module dep_ctrl
    import dep_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_stat_t   stat,
    output ctrl_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SEARCH   = 4'd2;
    localparam logic [3:0] S_COMPARE  = 4'd3;
    localparam logic [3:0] S_CHECK    = 4'd4;
    localparam logic [3:0] S_SH_RD    = 4'd5;
    localparam logic [3:0] S_SH_WR    = 4'd6;
    localparam logic [3:0] S_INS_WR   = 4'd7;
    localparam logic [3:0] S_POP_DATA = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    CMD_INSERT:
                    begin
                        cmd.srch_init = 1'b1;
                        state_next    = S_SEARCH;
                    end
                    CMD_POP_MAX, CMD_POP_MIN:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = (stat.op == CMD_POP_MAX) ? RD_LAST : RD_FIRST;
                            state_next = S_POP_DATA;
                        end
                    end
                    default:
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_IGNORED;
                        state_next     = S_FINISH;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (stat.lo_eq_hi)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.cmp_upd = 1'b1;
                state_next  = S_SEARCH;
            end
            S_CHECK:
            begin
                if (stat.found)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_IGNORED;
                    state_next     = S_FINISH;
                end
                else if (stat.cnt_full)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.idx_init = 1'b1;
                    state_next   = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                if (stat.idx_eq_lo)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_BELOW;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_dec  = 1'b1;
                state_next   = S_SH_RD;
            end
            S_INS_WR:
            begin
                cmd.wr_new     = 1'b1;
                cmd.cnt_inc    = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_INSERTED;
                state_next     = S_FINISH;
            end
            S_POP_DATA:
            begin
                cmd.cnt_dec      = 1'b1;
                cmd.head_inc     = (stat.op == CMD_POP_MIN);
                cmd.res_set      = 1'b1;
                cmd.res_from_mem = 1'b1;
                cmd.res_status   = ST_POPPED;
                state_next       = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/dep_dpath.sv -----
// entry memory, search and shift registers, result register of the queue
`default_nettype none

module dep_dpath
    import dep_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire in_word_t   in_word,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_word_t       out_word,
    input  wire ctrl_cmd_t  cmd,
    output dp_stat_t        stat
);

    // entries live in a ring: logical index 0 (smallest key) sits at head_reg
    entry_t            mem [CAPACITY];
    entry_t            rd_data_reg;

    in_word_t          item_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic              found_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic signed [31:0] res_value_reg;
    logic [2:0]        res_status_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic [CNT_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic [IDX_W-1:0]  rd_log;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_log;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              wr_en;

    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] offs);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, offs};
        if (s >= (IDX_W + 1)'(CAPACITY))
        begin
            s = s - (IDX_W + 1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];

    always_comb
    begin
        case (cmd.rd_sel)
            RD_MID:   rd_log = mid;
            RD_LAST:  rd_log = IDX_W'(count_reg - CNT_W'(1));
            RD_FIRST: rd_log = '0;
            RD_BELOW: rd_log = IDX_W'(idx_reg - CNT_W'(1));
            default:  rd_log = '0;
        endcase
    end

    assign rd_addr = ring_addr(head_reg, rd_log);
    assign wr_log  = cmd.wr_shift ? IDX_W'(idx_reg) : IDX_W'(lo_reg);
    assign wr_addr = ring_addr(head_reg, wr_log);
    assign wr_en   = cmd.wr_shift | cmd.wr_new;
    assign wr_data = cmd.wr_shift ? rd_data_reg : entry_t'{item_reg.key, item_reg.payload};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        head_next = head_reg;
        if (cmd.head_inc)
        begin
            head_next = ring_addr(head_reg, IDX_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            item_reg <= in_word;
        end
        if (cmd.srch_init)
        begin
            lo_reg    <= '0;
            hi_reg    <= count_reg;
            found_reg <= 1'b0;
        end
        else if (cmd.cmp_upd)
        begin
            // lower bound search: first entry whose key is not below the new key
            if (rd_data_reg.key < item_reg.key)
            begin
                lo_reg <= CNT_W'(mid) + CNT_W'(1);
            end
            else
            begin
                hi_reg    <= CNT_W'(mid);
                found_reg <= found_reg | (rd_data_reg.key == item_reg.key);
            end
        end
        if (cmd.idx_init)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - CNT_W'(1);
        end
        if (cmd.res_set)
        begin
            res_value_reg  <= cmd.res_from_mem ? rd_data_reg.payload : 32'sd0;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_word_reg <= out_word_t'{res_value_reg, res_status_reg};
        end
    end

    assign stat.op        = item_reg.cmd;
    assign stat.cnt_zero  = (count_reg == '0);
    assign stat.cnt_full  = (count_reg == CNT_W'(CAPACITY));
    assign stat.lo_eq_hi  = (lo_reg == hi_reg);
    assign stat.idx_eq_lo = (idx_reg == lo_reg);
    assign stat.found     = found_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ----- hdl/double_ended_priority_queue.sv -----
// top level of the double-ended priority queue: controller, datapath and checks
//
// Holds up to CAPACITY entries of distinct signed keys with payloads, kept sorted by key in a
// ring memory with a registered read port (one read or one write in any cycle). Every word in
// gives exactly one word out, and one word is processed at a time. A pop passes through decode,
// one memory read, then the result register; pop-smallest advances the ring head, pop-largest
// drops the tail. A pop on an empty queue or an unknown command goes from decode straight to
// the result. An insert runs a binary search over the stored keys, at most ceil(log2(count+1))
// steps, then, unless the key is a duplicate or the queue is full, moves every entry at or
// above the insert point up by one place. The shift through the memory port sets the worst
// case. A result held up by out_stall keeps the block in its last cycle. The memory needs no
// clearing after reset. A finished result waits in the output register while the next word is
// accepted.
`default_nettype none

module double_ended_priority_queue
    import dep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_word
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    dep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    dep_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cmd       (cmd),
        .stat      (stat)
    );

    // one word at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("word accepted while previous word still in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> !stat.cnt_zero)
        else $error("pop taken from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |-> (!stat.cnt_full && !stat.found))
        else $error("insert written into a full queue or over a duplicate key");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire
